// ===== hw/rtl/matrix4_vector_transform_top_assert.svh =====
// Assertion macros for the transform engine checker.
`ifndef MATRIX4_VECTOR_TRANSFORM_TOP_ASSERT_SVH
`define MATRIX4_VECTOR_TRANSFORM_TOP_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define MT4_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define MT4_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define MT4_ASSERT_ALWAYS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/mt4_pkg.sv =====
`default_nettype none

package mt4_pkg;

    localparam int unsigned DATA_WIDTH = 32;
    localparam int unsigned FRAC_BITS  = 16;
    localparam int unsigned LANES      = 4;
    localparam int unsigned LANE_W     = $clog2(LANES);
    localparam int unsigned PROD_W     = 2 * DATA_WIDTH;
    localparam int unsigned ACC_W      = PROD_W + LANE_W;

    typedef logic signed [DATA_WIDTH-1:0] t_word;
    typedef logic signed [PROD_W-1:0]     t_prod;
    typedef logic signed [ACC_W-1:0]      t_acc;
    typedef logic [LANE_W-1:0]            t_lane;

    typedef enum logic {
        ACT_LOAD  = 1'b0,
        ACT_XFORM = 1'b1
    } t_action;

    localparam t_word WORD_ONE = t_word'(1) <<< FRAC_BITS;
    localparam t_word WORD_MAX = t_word'({1'b0, {(DATA_WIDTH-1){1'b1}}});
    localparam t_word WORD_MIN = t_word'({1'b1, {(DATA_WIDTH-1){1'b0}}});
    localparam t_lane LAST_LANE = t_lane'(LANES - 1);

    typedef struct packed {
        t_action action;
        t_lane   coeff_row;
        t_lane   coeff_col;
        t_word   coeff_value;
        t_word   in_x0;
        t_word   in_x1;
        t_word   in_x2;
        t_word   in_x3;
    } t_req;

    typedef struct packed {
        t_word out_y0;
        t_word out_y1;
        t_word out_y2;
        t_word out_y3;
    } t_rsp;

    // one request as it travels down the cell chain
    typedef struct packed {
        logic                   valid;
        t_action                action;
        t_lane                  row;
        t_lane                  col;
        t_word                  value;
        t_word [LANES-1:0]      x;
    } t_item;

    typedef t_acc [LANES-1:0] t_psum;

    function automatic t_word coeff_reset(input t_lane row, input t_lane col);
        return (row == LAST_LANE && col == LAST_LANE) ? WORD_ONE : '0;
    endfunction

    // arithmetic shift by FRAC_BITS, then clamp to the word range
    function automatic t_word sat_shift(input t_acc a);
        t_acc s;
        s = a >>> FRAC_BITS;
        if (s[ACC_W-1:DATA_WIDTH-1] == {(ACC_W-DATA_WIDTH+1){s[ACC_W-1]}}) begin
            return t_word'(s[DATA_WIDTH-1:0]);
        end else if (s[ACC_W-1]) begin
            return WORD_MIN;
        end else begin
            return WORD_MAX;
        end
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mt4_stream_if.sv =====
`default_nettype none

interface mt4_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mt4_cell.sv =====
`default_nettype none

module mt4_cell import mt4_pkg::*; #(
    parameter int unsigned COL = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  t_item i_item,
    input  t_psum i_psum,
    output t_item o_item,
    output t_psum o_psum
);

    localparam t_lane MY_COL = t_lane'(COL);

    t_word r_coeff [LANES];
    t_prod r_prod  [LANES];
    t_item r_item_a;
    t_item r_item_b;
    t_psum r_psum_a;
    t_psum r_psum_b;

    logic w_load;

    assign w_load = i_en && i_item.valid && i_item.action == ACT_LOAD && i_item.col == MY_COL;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < LANES; r++) begin
                r_coeff[r] <= coeff_reset(t_lane'(r), MY_COL);
            end
            r_item_a.valid <= 1'b0;
            r_item_b.valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_coeff[i_item.row] <= i_item.value;
            end
            if (i_en) begin
                r_item_a <= i_item;
                r_item_b <= r_item_a;
            end
        end
    end

    // multiply stage, then accumulate onto the partial sums from upstream
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_psum_a <= i_psum;
            for (int r = 0; r < LANES; r++) begin
                r_prod[r]   <= t_prod'(r_coeff[r] * i_item.x[COL]);
                r_psum_b[r] <= r_psum_a[r] + t_acc'(r_prod[r]);
            end
        end
    end

    assign o_item = r_item_b;
    assign o_psum = r_psum_b;

endmodule

`default_nettype wire

// ===== hw/rtl/mt4_outreg.sv =====
`default_nettype none

module mt4_outreg import mt4_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_item i_item,
    input  t_psum i_psum,
    input  logic  i_ready,
    output logic  o_en,
    output logic  o_valid,
    output t_rsp  o_data
);

    logic r_valid;
    t_rsp r_data;

    assign o_en = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_en) begin
            r_valid <= i_item.valid && i_item.action == ACT_XFORM;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_data.out_y0 <= sat_shift(i_psum[0]);
            r_data.out_y1 <= sat_shift(i_psum[1]);
            r_data.out_y2 <= sat_shift(i_psum[2]);
            r_data.out_y3 <= sat_shift(i_psum[3]);
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ===== hw/rtl/matrix4_vector_transform_top.sv =====
// A transform request reaches o_rsp after it passes through four column cells
// of two register stages each, then through the output register.
// Throughput: one request per cycle; the whole cell chain advances together and
// halts only while a result sits in the output register and o_rsp.ready is low.
// Reset (i_rst_n low, synchronous): clears all valids and sets the
// matrix to zero except entry (3,3) = 1.0. No request is taken during reset.
`default_nettype none

module matrix4_vector_transform_top import mt4_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mt4_stream_if.sink   i_req,
    mt4_stream_if.source o_rsp
);

    t_item w_item [LANES+1];
    t_psum w_psum [LANES+1];
    logic  w_en;
    t_req  w_req;

    assign w_req = i_req.data;
    assign i_req.ready = i_rst_n && w_en;

    always_comb begin
        w_item[0].valid  = i_req.valid && i_req.ready;
        w_item[0].action = w_req.action;
        w_item[0].row    = w_req.coeff_row;
        w_item[0].col    = w_req.coeff_col;
        w_item[0].value  = w_req.coeff_value;
        w_item[0].x      = {w_req.in_x3, w_req.in_x2, w_req.in_x1, w_req.in_x0};
        w_psum[0]        = '0;
    end

    for (genvar g = 0; g < LANES; g++) begin : g_cell
        mt4_cell #(
            .COL (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_item  (w_item[g]),
            .i_psum  (w_psum[g]),
            .o_item  (w_item[g+1]),
            .o_psum  (w_psum[g+1])
        );
    end

    mt4_outreg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (w_item[LANES]),
        .i_psum  (w_psum[LANES]),
        .i_ready (o_rsp.ready),
        .o_en    (w_en),
        .o_valid (o_rsp.valid),
        .o_data  (o_rsp.data)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/mt4_checker.sv =====
`default_nettype none

`include "matrix4_vector_transform_top_assert.svh"

module mt4_checker import mt4_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input t_rsp i_out_data
);

    `MT4_ASSERT_ALWAYS(a_rst_clears, !i_rst_n, !i_out_valid, "result valid after reset")
    `MT4_ASSERT_NOW(a_no_block, !i_out_valid || i_out_ready, i_in_ready, "request blocked with free output")
    `MT4_ASSERT_NEXT(a_rsp_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_data), "stalled result changed")
    `MT4_ASSERT_NOW(a_stall_in, i_out_valid && !i_out_ready, !i_in_ready, "request taken while output stalled")

endmodule

bind matrix4_vector_transform_top mt4_checker u_mt4_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_out_data  (o_rsp.data)
);

`default_nettype wire
